[hdl/lirs_pkg.sv]
// Shared types and constants for the LIRS replacement policy block.
// No dependencies; imported by every other file of the block but lirs_checker.
`default_nettype none

package lirs_pkg;

    localparam int IN_KEY_BITS    = 32;
    localparam int LIR_CAP_BITS   = 5;
    localparam int HIR_CAP_BITS   = 4;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LIR_CAP = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIR_CAP = 1'd1;

    localparam logic [LIR_CAP_BITS-1:0] LIR_CAP_RESET = 5'd2;
    localparam logic [HIR_CAP_BITS-1:0] HIR_CAP_RESET = 4'd1;

    // stack entry marks
    localparam logic [1:0] MARK_LIR        = 2'd0;
    localparam logic [1:0] MARK_HIR_RES    = 2'd1;
    localparam logic [1:0] MARK_HIR_NONRES = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_PTR_CLR = 4'd2;
    localparam logic [3:0] OP_PTR_INC = 4'd3;
    localparam logic [3:0] OP_SET_S   = 4'd4;
    localparam logic [3:0] OP_SET_Q   = 4'd5;
    localparam logic [3:0] OP_RM_Q    = 4'd6;
    localparam logic [3:0] OP_RM_S    = 4'd7;
    localparam logic [3:0] OP_RM_PTR  = 4'd8;
    localparam logic [3:0] OP_FPOP    = 4'd9;
    localparam logic [3:0] OP_FAPPEND = 4'd10;
    localparam logic [3:0] OP_MARK_NR = 4'd11;
    localparam logic [3:0] OP_DEMOTE  = 4'd12;
    localparam logic [3:0] OP_SPUSH   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic       key_sel;   // scan: evicted key; append: demoted key
        logic [1:0] mark;
        logic       lir_inc;
        logic       lir_dec;
    } lirs_cmd_t;

    typedef struct packed {
        logic       s_end;
        logic       s_match;
        logic [1:0] s_mark;
        logic [1:0] s_idx_mark;
        logic [1:0] mark0;
        logic       s_found;
        logic       q_found;
        logic       q_end;
        logic       q_match;
        logic       stack_full;
        logic       stack_nz;
        logic       dem_end;
        logic       lir_room;
        logic       fifo_evict;
    } lirs_status_t;

endpackage

`default_nettype wire

[hdl/lirs_if.sv]
// Valid/ready channel interfaces for the LIRS block: request and response.
// Depends on lirs_pkg.
`default_nettype none

interface lirs_req_if import lirs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [IN_KEY_BITS-1:0] access_key;

    modport source (output valid, output access_key, input ready);
    modport sink   (input valid, input access_key, output ready);
endinterface

interface lirs_rsp_if import lirs_pkg::*; ();
    logic valid;
    logic ready;
    logic was_hit;

    modport source (output valid, output was_hit, input ready);
    modport sink   (input valid, input was_hit, output ready);
endinterface

`default_nettype wire

[hdl/lirs_dp.sv]
// LIRS datapath: recency stack, resident-HIR FIFO, counters and scan pointer.
// Executes one command per cycle from lirs_ctrl; depends on lirs_pkg.
`default_nettype none

module lirs_dp import lirs_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int FIFO_DEPTH  = 8,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [IN_KEY_BITS-1:0]  in_key,
    input  wire logic [LIR_CAP_BITS-1:0] lir_cap,
    input  wire logic [HIR_CAP_BITS-1:0] hir_cap,
    input  wire lirs_cmd_t               cmd,
    output lirs_status_t                 status
);

    localparam int KW   = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
    localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW   = $clog2(STACK_DEPTH + 1);
    localparam int FW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int QW   = $clog2(FIFO_DEPTH + 1);
    localparam int MAXD = (STACK_DEPTH > FIFO_DEPTH) ? STACK_DEPTH : FIFO_DEPTH;
    localparam int PW   = $clog2(MAXD + 1);
    localparam int LW   = (CW > LIR_CAP_BITS) ? CW : LIR_CAP_BITS;
    localparam int HW   = (QW > HIR_CAP_BITS) ? QW : HIR_CAP_BITS;

    logic [KW-1:0] skey_reg [STACK_DEPTH];
    logic [1:0]    smark_reg[STACK_DEPTH];
    logic [KW-1:0] fkey_reg [FIFO_DEPTH];
    logic [CW-1:0] scount_reg;
    logic [QW-1:0] fcount_reg;
    logic [CW-1:0] lir_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] ev_key_reg;
    logic [KW-1:0] dem_key_reg;
    logic [PW-1:0] ptr_reg;
    logic [SW-1:0] s_idx_reg;
    logic [FW-1:0] q_idx_reg;
    logic          s_found_reg;
    logic          q_found_reg;

    logic [SW-1:0] sp;
    logic [FW-1:0] fp;
    logic [KW-1:0] cmp_key;
    logic [KW-1:0] app_key;
    logic [SW-1:0] rm_idx;
    logic [HW-1:0] fcap;
    logic          fifo_room;

    assign sp        = ptr_reg[SW-1:0];
    assign fp        = ptr_reg[FW-1:0];
    assign cmp_key   = cmd.key_sel ? ev_key_reg : key_reg;
    assign app_key   = cmd.key_sel ? dem_key_reg : key_reg;
    assign rm_idx    = (cmd.op == OP_RM_S) ? s_idx_reg : sp;
    assign fifo_room = fcount_reg < QW'(FIFO_DEPTH);

    // effective FIFO limit: register clamped to 1..FIFO_DEPTH
    always_comb
    begin
        if (hir_cap == '0)
            fcap = HW'(1);
        else if (HW'(hir_cap) > HW'(FIFO_DEPTH))
            fcap = HW'(FIFO_DEPTH);
        else
            fcap = HW'(hir_cap);
    end

    always_comb
    begin
        status.s_end      = ptr_reg >= PW'(scount_reg);
        status.s_match    = skey_reg[sp] == cmp_key;
        status.s_mark     = smark_reg[sp];
        status.s_idx_mark = smark_reg[s_idx_reg];
        status.mark0      = smark_reg[0];
        status.s_found    = s_found_reg;
        status.q_found    = q_found_reg;
        status.q_end      = ptr_reg >= PW'(fcount_reg);
        status.q_match    = fkey_reg[fp] == key_reg;
        status.stack_full = scount_reg >= CW'(STACK_DEPTH);
        status.stack_nz   = scount_reg != '0;
        status.dem_end    = ((PW + 1)'(ptr_reg) + (PW + 1)'(1)) >= (PW + 1)'(scount_reg);
        status.lir_room   = LW'(lir_reg) < LW'(lir_cap);
        status.fifo_evict = (fcount_reg != '0) && (HW'(fcount_reg) >= fcap);
    end

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                key_reg <= in_key[KW-1:0];
            end
            OP_RM_S, OP_RM_PTR, OP_DEMOTE:
            begin
                if (cmd.op == OP_DEMOTE)
                    dem_key_reg <= skey_reg[sp];
                for (int j = 0; j < STACK_DEPTH - 1; j++)
                begin
                    if (j >= int'(rm_idx))
                    begin
                        skey_reg[j]  <= skey_reg[j+1];
                        smark_reg[j] <= smark_reg[j+1];
                    end
                end
            end
            OP_FPOP, OP_RM_Q:
            begin
                if (cmd.op == OP_FPOP)
                    ev_key_reg <= fkey_reg[0];
                for (int j = 0; j < FIFO_DEPTH - 1; j++)
                begin
                    if (cmd.op == OP_FPOP || j >= int'(q_idx_reg))
                        fkey_reg[j] <= fkey_reg[j+1];
                end
            end
            OP_FAPPEND:
            begin
                if (fifo_room)
                    fkey_reg[fcount_reg[FW-1:0]] <= app_key;
            end
            OP_MARK_NR:
            begin
                smark_reg[sp] <= MARK_HIR_NONRES;
            end
            OP_SPUSH:
            begin
                skey_reg[scount_reg[SW-1:0]]  <= key_reg;
                smark_reg[scount_reg[SW-1:0]] <= cmd.mark;
            end
            default:
            begin
            end
        endcase
    end

    // counters, pointer and search results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scount_reg  <= '0;
            fcount_reg  <= '0;
            lir_reg     <= '0;
            ptr_reg     <= '0;
            s_idx_reg   <= '0;
            q_idx_reg   <= '0;
            s_found_reg <= 1'b0;
            q_found_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    ptr_reg     <= '0;
                    s_found_reg <= 1'b0;
                    q_found_reg <= 1'b0;
                end
                OP_PTR_CLR:
                begin
                    ptr_reg <= '0;
                end
                OP_PTR_INC:
                begin
                    ptr_reg <= ptr_reg + PW'(1);
                end
                OP_SET_S:
                begin
                    s_idx_reg   <= sp;
                    s_found_reg <= 1'b1;
                    ptr_reg     <= '0;
                end
                OP_SET_Q:
                begin
                    q_idx_reg   <= fp;
                    q_found_reg <= 1'b1;
                end
                OP_RM_Q:
                begin
                    fcount_reg <= fcount_reg - QW'(1);
                end
                OP_RM_S:
                begin
                    scount_reg <= scount_reg - CW'(1);
                end
                OP_RM_PTR, OP_DEMOTE:
                begin
                    scount_reg <= scount_reg - CW'(1);
                    if ((cmd.op == OP_DEMOTE || cmd.lir_dec) && lir_reg != '0)
                        lir_reg <= lir_reg - CW'(1);
                end
                OP_FPOP:
                begin
                    fcount_reg <= fcount_reg - QW'(1);
                    ptr_reg    <= '0;
                end
                OP_FAPPEND:
                begin
                    if (fifo_room)
                        fcount_reg <= fcount_reg + QW'(1);
                    ptr_reg <= '0;
                end
                OP_SPUSH:
                begin
                    scount_reg <= scount_reg + CW'(1);
                    lir_reg    <= lir_reg + CW'(cmd.lir_inc);
                    ptr_reg    <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/lirs_ctrl.sv]
// LIRS controller: sequences search, remove, push, demote, evict and prune
// steps, holds the configuration and result registers. Depends on lirs_pkg.
`default_nettype none

module lirs_ctrl import lirs_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_hit,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic [LIR_CAP_BITS-1:0]        lir_cap,
    output logic [HIR_CAP_BITS-1:0]        hir_cap,
    output lirs_cmd_t                      cmd,
    input  wire lirs_status_t              status
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SFIND  = 4'd1;
    localparam logic [3:0] ST_QFIND  = 4'd2;
    localparam logic [3:0] ST_DECIDE = 4'd3;
    localparam logic [3:0] ST_RMQ    = 4'd4;
    localparam logic [3:0] ST_RMS    = 4'd5;
    localparam logic [3:0] ST_FCHK   = 4'd6;
    localparam logic [3:0] ST_FSCAN  = 4'd7;
    localparam logic [3:0] ST_PCHK   = 4'd8;
    localparam logic [3:0] ST_PSCAN1 = 4'd9;
    localparam logic [3:0] ST_PSCAN2 = 4'd10;
    localparam logic [3:0] ST_PRM    = 4'd11;
    localparam logic [3:0] ST_PWR    = 4'd12;
    localparam logic [3:0] ST_DEM    = 4'd13;
    localparam logic [3:0] ST_PRUNE  = 4'd14;
    localparam logic [3:0] ST_DONE   = 4'd15;

    logic [3:0]              state_reg, state_next;
    logic                    rmq_reg, rmq_next;
    logic                    rms_reg, rms_next;
    logic                    fp_reg, fp_next;
    logic                    dem_reg, dem_next;
    logic                    ret_dem_reg, ret_dem_next;
    logic                    drop_reg, drop_next;
    logic                    inc_reg, inc_next;
    logic [1:0]              mark_reg, mark_next;
    logic                    hit_reg, hit_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic [LIR_CAP_BITS-1:0] lir_cap_reg, lir_cap_next;
    logic [HIR_CAP_BITS-1:0] hir_cap_reg, hir_cap_next;

    logic is_lir;

    assign is_lir    = status.s_found && (status.s_idx_mark == MARK_LIR);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign lir_cap   = lir_cap_reg;
    assign hir_cap   = hir_cap_reg;

    always_comb
    begin
        state_next     = state_reg;
        rmq_next       = rmq_reg;
        rms_next       = rms_reg;
        fp_next        = fp_reg;
        dem_next       = dem_reg;
        ret_dem_next   = ret_dem_reg;
        drop_next      = drop_reg;
        inc_next       = inc_reg;
        mark_next      = mark_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        lir_cap_next   = lir_cap_reg;
        hir_cap_next   = hir_cap_reg;
        cmd            = '{op: OP_NOP, key_sel: 1'b0, mark: MARK_LIR,
                           lir_inc: 1'b0, lir_dec: 1'b0};

        if (cfg_we)
        begin
            case (cfg_index)
                REG_LIR_CAP: lir_cap_next = cfg_data[LIR_CAP_BITS-1:0];
                REG_HIR_CAP: hir_cap_next = cfg_data[HIR_CAP_BITS-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SFIND;
                end
            end
            ST_SFIND:
            begin
                if (status.s_end)
                begin
                    cmd.op     = OP_PTR_CLR;
                    state_next = ST_QFIND;
                end
                else if (status.s_match)
                begin
                    cmd.op     = OP_SET_S;
                    state_next = ST_QFIND;
                end
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_QFIND:
            begin
                if (status.q_end)
                    state_next = ST_DECIDE;
                else if (status.q_match)
                begin
                    cmd.op     = OP_SET_Q;
                    state_next = ST_DECIDE;
                end
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_DECIDE:
            begin
                hit_next   = is_lir || status.q_found;
                rmq_next   = status.q_found;
                rms_next   = status.s_found;
                fp_next    = 1'b0;
                dem_next   = 1'b0;
                inc_next   = 1'b1;
                mark_next  = MARK_LIR;
                state_next = ST_RMQ;
                if (is_lir)
                begin
                    rmq_next = 1'b0;
                    inc_next = 1'b0;
                end
                else if (!status.lir_room)
                begin
                    if (status.s_found)
                        dem_next = 1'b1;   // promote HIR, demote lowest LIR
                    else
                    begin
                        fp_next   = 1'b1;
                        inc_next  = 1'b0;
                        mark_next = MARK_HIR_RES;
                    end
                end
            end
            ST_RMQ:
            begin
                if (rmq_reg)
                    cmd.op = OP_RM_Q;
                state_next = ST_RMS;
            end
            ST_RMS:
            begin
                if (rms_reg)
                    cmd.op = OP_RM_S;
                ret_dem_next = 1'b0;
                state_next   = fp_reg ? ST_FCHK : ST_PCHK;
            end
            ST_FCHK:
            begin
                if (status.fifo_evict)
                begin
                    cmd.op     = OP_FPOP;
                    state_next = ST_FSCAN;
                end
                else
                begin
                    cmd.op      = OP_FAPPEND;
                    cmd.key_sel = ret_dem_reg;
                    state_next  = ret_dem_reg ? ST_PRUNE : ST_PCHK;
                end
            end
            ST_FSCAN:
            begin
                // evicted block: first stack entry with its key goes non-resident if marked resident HIR
                cmd.key_sel = 1'b1;
                if (status.s_end)
                    state_next = ST_FCHK;
                else if (status.s_match)
                begin
                    if (status.s_mark == MARK_HIR_RES)
                        cmd.op = OP_MARK_NR;
                    state_next = ST_FCHK;
                end
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_PCHK:
            begin
                cmd.op    = OP_PTR_CLR;
                drop_next = 1'b0;
                state_next = status.stack_full ? ST_PSCAN1 : ST_PWR;
            end
            ST_PSCAN1:
            begin
                if (status.s_end)
                begin
                    cmd.op     = OP_PTR_CLR;
                    state_next = ST_PSCAN2;
                end
                else if (status.s_mark == MARK_HIR_NONRES)
                    state_next = ST_PRM;
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_PSCAN2:
            begin
                if (status.s_end)
                begin
                    cmd.op     = OP_PTR_CLR;
                    drop_next  = 1'b1;
                    state_next = ST_PRM;
                end
                else if (status.s_mark == MARK_HIR_RES)
                    state_next = ST_PRM;
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_PRM:
            begin
                cmd.op      = OP_RM_PTR;
                cmd.lir_dec = drop_reg && (status.mark0 == MARK_LIR);
                state_next  = ST_PWR;
            end
            ST_PWR:
            begin
                cmd.op      = OP_SPUSH;
                cmd.mark    = mark_reg;
                cmd.lir_inc = inc_reg;
                state_next  = dem_reg ? ST_DEM : ST_PRUNE;
            end
            ST_DEM:
            begin
                if (status.dem_end)
                begin
                    cmd.op     = OP_PTR_CLR;
                    state_next = ST_PRUNE;
                end
                else if (status.s_mark == MARK_LIR)
                begin
                    cmd.op       = OP_DEMOTE;
                    ret_dem_next = 1'b1;
                    state_next   = ST_FCHK;
                end
                else
                    cmd.op = OP_PTR_INC;
            end
            ST_PRUNE:
            begin
                // pointer is zero here: removal at the pointer pops the bottom
                if (status.stack_nz && status.mark0 != MARK_LIR)
                    cmd.op = OP_RM_PTR;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rmq_reg       <= 1'b0;
            rms_reg       <= 1'b0;
            fp_reg        <= 1'b0;
            dem_reg       <= 1'b0;
            ret_dem_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            inc_reg       <= 1'b0;
            mark_reg      <= MARK_LIR;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            lir_cap_reg   <= LIR_CAP_RESET;
            hir_cap_reg   <= HIR_CAP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            rmq_reg       <= rmq_next;
            rms_reg       <= rms_next;
            fp_reg        <= fp_next;
            dem_reg       <= dem_next;
            ret_dem_reg   <= ret_dem_next;
            drop_reg      <= drop_next;
            inc_reg       <= inc_next;
            mark_reg      <= mark_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            lir_cap_reg   <= lir_cap_next;
            hir_cap_reg   <= hir_cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg <= out_hit_next;
    end

endmodule

`default_nettype wire

[hdl/lirs_replacement_policy_top.sv]
// LIRS replacement policy top level: controller plus datapath.
// Depends on lirs_pkg, lirs_if, lirs_ctrl and lirs_dp.
//
// One access key per request word, one hit/miss response word per request.
// Items are handled one at a time. The entry-by-entry stack scans (one entry per
// cycle) take most of the time of an item: the key search, the overflow victim
// search, the demote search and the bottom prune each walk the live stack, and
// every FIFO eviction rescans it for the evicted key. After the HIR capacity has
// been lowered a single item may evict the whole FIFO, which dominates the worst
// case. A finished response sits in an output register, so the next request
// is taken while it waits; a response still waiting when the next item ends
// holds that item, and the input, until it is taken.
// Configuration writes: index 0 LIR capacity, index 1 HIR capacity; write
// only while the block is idle.
`default_nettype none

module lirs_replacement_policy_top import lirs_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int FIFO_DEPTH  = 8,
    parameter int KEY_BITS    = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lirs_req_if.sink                       req,
    lirs_rsp_if.source                     rsp,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    lirs_cmd_t               cmd;
    lirs_status_t            status;
    logic [LIR_CAP_BITS-1:0] lir_cap;
    logic [HIR_CAP_BITS-1:0] hir_cap;

    lirs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_hit   (rsp.was_hit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .lir_cap   (lir_cap),
        .hir_cap   (hir_cap),
        .cmd       (cmd),
        .status    (status)
    );

    lirs_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .FIFO_DEPTH  (FIFO_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_key  (req.access_key),
        .lir_cap (lir_cap),
        .hir_cap (hir_cap),
        .cmd     (cmd),
        .status  (status)
    );

endmodule

`default_nettype wire

[hdl/lirs_checker.sv]
// Port-level checks for the LIRS block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module lirs_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_was_hit
);

    // a response word stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before accept");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_was_hit))
        else $error("stalled response changed");

    // one item at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // a response appears only as the block finishes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response without a request in flight");

endmodule

bind lirs_replacement_policy_top lirs_checker u_lirs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_was_hit (rsp.was_hit)
);

`default_nettype wire

[tb/tb_top.sv]
// Testbench for the LIRS replacement policy block: random and directed access keys,
// with a built-in LIRS predictor and a hit/miss scoreboard.
// Depends on lirs_pkg, lirs_if and lirs_replacement_policy_top.
`default_nettype none

module tb_top;
    import lirs_pkg::*;

    localparam int SDEPTH = 32;
    localparam int FDEPTH = 8;
    localparam int WDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    lirs_req_if req ();
    lirs_rsp_if rsp ();

    lirs_replacement_policy_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] stk_key [SDEPTH];
    logic [1:0]  stk_mark [SDEPTH];
    int          stk_n;
    logic [31:0] hq_key [FDEPTH];
    int          hq_n;
    int          lir_n;
    int          lir_cap;
    int          hir_cap;

    logic [31:0] key_queue [$];
    logic        hit_queue [$];
    int          mismatches = 0;
    int          rsp_seen = 0;
    bit          no_idle = 1'b0;
    bit          src_pause = 1'b0;
    int          sink_hold = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    function automatic void enqueue_key(logic [31:0] k);
        key_queue.insert(key_queue.size(), k);
    endfunction

    function automatic int stk_find(logic [31:0] k);
        for (int i = 0; i < stk_n; i++)
            if (stk_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic int hq_find(logic [31:0] k);
        for (int i = 0; i < hq_n; i++)
            if (hq_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void stk_drop(int i);
        if (i >= stk_n)
            return;
        for (int j = i; j < stk_n - 1; j++)
        begin
            stk_key[j] = stk_key[j+1];
            stk_mark[j] = stk_mark[j+1];
        end
        stk_n--;
    endfunction

    function automatic void hq_drop(int i);
        if (i >= hq_n)
            return;
        for (int j = i; j < hq_n - 1; j++)
            hq_key[j] = hq_key[j+1];
        hq_n--;
    endfunction

    function automatic void hq_append(logic [31:0] k);
        int limit;
        int s;
        logic [31:0] old;
        limit = hir_cap < 1 ? 1 : (hir_cap > FDEPTH ? FDEPTH : hir_cap);
        while (hq_n > 0 && hq_n >= limit)
        begin
            old = hq_key[0];
            hq_drop(0);
            s = stk_find(old);
            if (s >= 0 && stk_mark[s] == MARK_HIR_RES)
                stk_mark[s] = MARK_HIR_NONRES;
        end
        if (hq_n < FDEPTH)
        begin
            hq_key[hq_n] = k;
            hq_n++;
        end
    endfunction

    function automatic void stk_push(logic [31:0] k, logic [1:0] m);
        int victim;
        bit found;
        victim = 0;
        found = 1'b0;
        if (stk_n >= SDEPTH)
        begin
            for (int i = 0; i < stk_n && !found; i++)
                if (stk_mark[i] == MARK_HIR_NONRES)
                begin
                    victim = i;
                    found = 1'b1;
                end
            for (int i = 0; i < stk_n && !found; i++)
                if (stk_mark[i] == MARK_HIR_RES)
                begin
                    victim = i;
                    found = 1'b1;
                end
            if (!found && stk_mark[0] == MARK_LIR && lir_n > 0)
                lir_n--;
            stk_drop(victim);
        end
        stk_key[stk_n] = k;
        stk_mark[stk_n] = m;
        stk_n++;
    endfunction

    function automatic void demote_lowest_lir();
        logic [31:0] k;
        for (int i = 0; i + 1 < stk_n; i++)
            if (stk_mark[i] == MARK_LIR)
            begin
                k = stk_key[i];
                stk_drop(i);
                if (lir_n > 0)
                    lir_n--;
                hq_append(k);
                return;
            end
    endfunction

    function automatic logic lirs_access(logic [31:0] k);
        int s;
        int q;
        bit is_lir;
        s = stk_find(k);
        q = hq_find(k);
        is_lir = (s >= 0) && (stk_mark[s] == MARK_LIR);
        if (is_lir)
        begin
            stk_drop(s);
            stk_push(k, MARK_LIR);
        end
        else if (lir_n < lir_cap)
        begin
            if (q >= 0)
                hq_drop(q);
            if (s >= 0)
                stk_drop(s);
            stk_push(k, MARK_LIR);
            lir_n++;
        end
        else if (s >= 0)
        begin
            if (q >= 0)
                hq_drop(q);
            stk_drop(s);
            stk_push(k, MARK_LIR);
            lir_n++;
            demote_lowest_lir();
        end
        else
        begin
            if (q >= 0)
                hq_drop(q);
            hq_append(k);
            stk_push(k, MARK_HIR_RES);
        end
        while (stk_n > 0 && stk_mark[0] != MARK_LIR)
            stk_drop(0);
        return is_lir || (q >= 0);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch: %s", what);
        mismatches++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.access_key <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (key_queue.size() > 0 && !src_pause && (no_idle || $urandom_range(99) >= 17))
            begin
                req.valid <= 1'b1;
                req.access_key <= key_queue[0];
                key_queue.delete(0);
            end
            else
                req.valid <= 1'b0;
        end
    end

    // prediction at acceptance
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            hit_queue.insert(hit_queue.size(), lirs_access(req.access_key));
    end

    // response side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            rsp.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
            rsp.ready <= no_idle || $urandom_range(99) >= 17;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            rsp_seen++;
            if (hit_queue.size() == 0)
                report_mismatch("response word with nothing expected");
            else
            begin
                logic exp_hit;
                exp_hit = hit_queue[0];
                hit_queue.delete(0);
                if (rsp.was_hit !== exp_hit)
                    report_mismatch($sformatf("was_hit %b, expected %b (word %0d)",
                        rsp.was_hit, exp_hit, rsp_seen));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LIR_CAP)
            lir_cap = value & 5'h1F;
        else
            hir_cap = value & 4'hF;
    endtask

    task automatic wait_drained();
        while (key_queue.size() > 0 || req.valid || hit_queue.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // small key pool keeps hits frequent; occasionally any 32-bit key
    function automatic logic [31:0] pick_key(int pool);
        if ($urandom_range(99) < 8)
            return $urandom();
        return 32'h5A00_0000 + $urandom_range(pool - 1);
    endfunction

    initial
    begin
        static int lcaps [6] = '{1, 16, 3, 8, 2, 5};
        static int hcaps [6] = '{1, 8, 2, 4, 1, 3};
        stk_n = 0;
        hq_n = 0;
        lir_n = 0;
        lir_cap = LIR_CAP_RESET;
        hir_cap = HIR_CAP_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: key extremes, warm-up, hits on LIR and HIR, misses
        enqueue_key(32'h0000_0000);
        enqueue_key(32'hFFFF_FFFF);
        enqueue_key(32'h0000_0000);
        enqueue_key(32'hFFFF_FFFF);
        enqueue_key(32'hAAAA_AAAA);
        enqueue_key(32'h5555_5555);
        enqueue_key(32'hAAAA_AAAA);
        enqueue_key(32'h5555_5555);
        enqueue_key(32'h0000_0000);
        enqueue_key(32'hAAAA_AAAA);
        enqueue_key(32'h1234_5678);
        enqueue_key(32'hAAAA_AAAA);
        wait_drained();

        // lower HIR capacity with a full FIFO, then lower LIR capacity
        write_reg(REG_HIR_CAP, 8);
        for (int i = 0; i < 10; i++)
            enqueue_key(32'h7000_0000 + i);
        wait_drained();
        write_reg(REG_HIR_CAP, 0);
        write_reg(REG_LIR_CAP, 0);
        for (int i = 0; i < 8; i++)
            enqueue_key(32'h7000_0000 + (i % 5));
        wait_drained();

        // stack overflow: many distinct keys with large capacities
        write_reg(REG_LIR_CAP, 31);
        write_reg(REG_HIR_CAP, 15);
        for (int i = 0; i < 45; i++)
            enqueue_key(32'h3000_0000 + i);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_LIR_CAP, lcaps[ph]);
            write_reg(REG_HIR_CAP, hcaps[ph]);
            no_idle = (ph == 2);
            for (int i = 0; i < 300; i++)
                enqueue_key(pick_key(lcaps[ph] + hcaps[ph] + 6));
            if (ph == 3)
            begin
                // long receiver stall while the sender keeps offering
                @(posedge clk);
                sink_hold <= 300;
            end
            if (ph == 4)
            begin
                // sender pauses until all expected words are back
                while (key_queue.size() > 150)
                    @(posedge clk);
                src_pause = 1'b1;
                while (req.valid || hit_queue.size() > 0)
                    @(posedge clk);
                src_pause = 1'b0;
            end
            wait_drained();
        end
        no_idle = 1'b0;

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

[filelist.f]
hdl/lirs_pkg.sv
hdl/lirs_if.sv
hdl/lirs_dp.sv
hdl/lirs_ctrl.sv
hdl/lirs_replacement_policy_top.sv
hdl/lirs_checker.sv
tb/tb_top.sv
